// ----- rtl/core/vsd_pkg.sv -----
// ----------------------------------------------------------------------------
// vsd_pkg
// shared types, codes and constants of the video stream deframer
// ----------------------------------------------------------------------------
package vsd_pkg;

  localparam int unsigned TIMER_WIDTH_DEF = 24;
  localparam int unsigned CFG_TIMER_W     = 24;

  localparam logic [31:0] MAGIC_WORD = 32'h0004_2069;
  localparam logic [7:0]  TYPE_I     = 8'h01;
  localparam logic [7:0]  TYPE_WAIT  = 8'hFF;

  localparam logic [23:0] DROP_THRESHOLD_RST = 24'd50000;
  localparam logic [23:0] WATCHDOG_RST       = 24'd3000000;
  localparam logic [31:0] MAX_FRAME_RST      = 32'd1000000;

  // operations
  localparam logic [1:0] OP_BYTE       = 2'd0;
  localparam logic [1:0] OP_TICK       = 2'd1;
  localparam logic [1:0] OP_CONNECT    = 2'd2;
  localparam logic [1:0] OP_DISCONNECT = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_START   = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;

  // end causes
  localparam logic [1:0] CAUSE_DISCONNECT = 2'd0;
  localparam logic [1:0] CAUSE_OVERSIZE   = 2'd1;
  localparam logic [1:0] CAUSE_WATCHDOG   = 2'd2;

  // register indexes
  localparam logic [1:0] REG_DROP_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_WATCHDOG       = 2'd1;
  localparam logic [1:0] REG_MAX_FRAME      = 2'd2;

  typedef struct packed {
    logic [CFG_TIMER_W-1:0] drop_threshold_ticks;
    logic [CFG_TIMER_W-1:0] watchdog_ticks;
    logic [31:0]            max_frame_bytes;
  } vsd_cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] width;
    logic [31:0] height;
    logic [31:0] frames_per_second;
    logic [7:0]  payload;
    logic        last;
    logic        keep;
    logic [7:0]  kind_of_frame;
    logic [1:0]  end_cause;
  } vsd_result_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [31:0] sh;
    sh = MAGIC_WORD >> {idx, 3'b000};
    return sh[7:0];
  endfunction

endpackage

// ----- rtl/core/vsd_in_if.sv -----
// ----------------------------------------------------------------------------
// vsd_in_if
// input item channel: operation and stream byte
// ----------------------------------------------------------------------------
interface vsd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] data_byte;

  modport source (output valid, output operation, output data_byte, input ready);
  modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

// ----- rtl/core/vsd_out_if.sv -----
// ----------------------------------------------------------------------------
// vsd_out_if
// result channel: session start, payload byte and session end
// ----------------------------------------------------------------------------
interface vsd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] width;
  logic [31:0] height;
  logic [31:0] frames_per_second;
  logic [7:0]  payload;
  logic        last;
  logic        keep;
  logic [7:0]  kind_of_frame;
  logic [1:0]  end_cause;

  modport source (output valid, output kind, output width, output height,
                  output frames_per_second, output payload, output last,
                  output keep, output kind_of_frame, output end_cause,
                  input ready);
  modport sink   (input valid, input kind, input width, input height,
                  input frames_per_second, input payload, input last,
                  input keep, input kind_of_frame, input end_cause,
                  output ready);
endinterface

// ----- rtl/core/vsd_cfg_if.sv -----
// ----------------------------------------------------------------------------
// vsd_cfg_if
// register write channel
// ----------------------------------------------------------------------------
interface vsd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/vsd_engine.sv -----
// ----------------------------------------------------------------------------
// vsd_engine
// session state machine: magic search, header, length, type and payload
// ----------------------------------------------------------------------------
module vsd_engine
  import vsd_pkg::*;
#(
  parameter int unsigned TIMER_WIDTH = TIMER_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [1:0]  operation,
  input  logic [7:0]  data_byte,
  input  vsd_cfg_t    cfg,
  output logic        res_valid,
  output vsd_result_t res
);

  localparam int unsigned CW = (TIMER_WIDTH > CFG_TIMER_W) ? TIMER_WIDTH : CFG_TIMER_W;

  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_MAGIC   = 3'd1;
  localparam logic [2:0] MODE_HEADER  = 3'd2;
  localparam logic [2:0] MODE_LENGTH  = 3'd3;
  localparam logic [2:0] MODE_TYPE    = 3'd4;
  localparam logic [2:0] MODE_PAYLOAD = 3'd5;

  logic [2:0]             mode, mode_next;
  logic [3:0]             byte_count, byte_count_next;
  logic [95:0]            header, header_next;
  logic [31:0]            frame_length, frame_length_next;
  logic [31:0]            payload_count, payload_count_next;
  logic [7:0]             current_type, current_type_next;
  logic                   first_frame, first_frame_next;
  logic [TIMER_WIDTH-1:0] elapsed, elapsed_next;
  logic [TIMER_WIDTH-1:0] wd_count, wd_count_next;
  logic                   wd_armed, wd_armed_next;

  logic [TIMER_WIDTH-1:0] wd_inc;
  logic [31:0]            pc_inc;
  logic                   fin;
  logic                   drop;

  always_comb begin
    mode_next          = mode;
    byte_count_next    = byte_count;
    header_next        = header;
    frame_length_next  = frame_length;
    payload_count_next = payload_count;
    current_type_next  = current_type;
    first_frame_next   = first_frame;
    elapsed_next       = elapsed;
    wd_count_next      = wd_count;
    wd_armed_next      = wd_armed;
    res_valid          = 1'b0;
    res                = '0;
    wd_inc             = (wd_count == '1) ? wd_count : wd_count + 1'b1;
    pc_inc             = payload_count + 32'd1;
    fin                = (pc_inc == frame_length) || (payload_count == '1);
    drop               = !first_frame && (current_type != TYPE_I) &&
                         (CW'(elapsed) >= CW'(cfg.drop_threshold_ticks));

    if (step) begin
      if (operation == OP_CONNECT) begin
        if (mode == MODE_IDLE) begin
          mode_next       = MODE_MAGIC;
          byte_count_next = 4'd0;
        end
      end else if (mode != MODE_IDLE) begin
        case (operation)
          OP_DISCONNECT: begin
            mode_next       = MODE_IDLE;
            byte_count_next = 4'd0;
            wd_armed_next   = 1'b0;
            wd_count_next   = '0;
            res_valid       = 1'b1;
            res.kind        = KIND_END;
            res.end_cause   = CAUSE_DISCONNECT;
          end
          OP_TICK: begin
            if (elapsed != '1) begin
              elapsed_next = elapsed + 1'b1;
            end
            if (wd_armed) begin
              wd_count_next = wd_inc;
              if (CW'(wd_inc) >= CW'(cfg.watchdog_ticks)) begin
                mode_next       = MODE_IDLE;
                byte_count_next = 4'd0;
                wd_armed_next   = 1'b0;
                wd_count_next   = '0;
                res_valid       = 1'b1;
                res.kind        = KIND_END;
                res.end_cause   = CAUSE_WATCHDOG;
              end
            end
          end
          default: begin
            unique case (mode)
              MODE_MAGIC: begin
                if (data_byte == magic_byte(byte_count[1:0])) begin
                  if (byte_count[1:0] == 2'd3) begin
                    byte_count_next = 4'd0;
                    header_next     = '0;
                    mode_next       = MODE_HEADER;
                  end else begin
                    byte_count_next = byte_count + 4'd1;
                  end
                end else begin
                  byte_count_next = 4'd0;
                end
              end
              MODE_HEADER: begin
                for (int k = 0; k < 12; k++) begin
                  if (byte_count == 4'(k)) begin
                    header_next[k*8 +: 8] = data_byte;
                  end
                end
                if (byte_count == 4'd11) begin
                  byte_count_next       = 4'd0;
                  mode_next             = MODE_LENGTH;
                  frame_length_next     = '0;
                  payload_count_next    = '0;
                  current_type_next     = TYPE_WAIT;
                  first_frame_next      = 1'b1;
                  elapsed_next          = '0;
                  res_valid             = 1'b1;
                  res.kind              = KIND_START;
                  res.width             = header_next[31:0];
                  res.height            = header_next[63:32];
                  res.frames_per_second = header_next[95:64];
                end else begin
                  byte_count_next = byte_count + 4'd1;
                end
              end
              MODE_LENGTH: begin
                frame_length_next = (byte_count[1:0] == 2'd0) ? 32'd0 : frame_length;
                for (int k = 0; k < 4; k++) begin
                  if (byte_count[1:0] == 2'(k)) begin
                    frame_length_next[k*8 +: 8] = data_byte;
                  end
                end
                if (byte_count[1:0] == 2'd3) begin
                  byte_count_next = 4'd0;
                  if (frame_length_next > cfg.max_frame_bytes) begin
                    mode_next     = MODE_IDLE;
                    wd_armed_next = 1'b0;
                    wd_count_next = '0;
                    res_valid     = 1'b1;
                    res.kind      = KIND_END;
                    res.end_cause = CAUSE_OVERSIZE;
                  end else if (frame_length_next != 32'd0) begin
                    mode_next = MODE_TYPE;
                  end
                end else begin
                  byte_count_next = {2'b00, byte_count[1:0]} + 4'd1;
                end
              end
              MODE_TYPE: begin
                if (data_byte != TYPE_WAIT) begin
                  current_type_next  = data_byte;
                  payload_count_next = '0;
                  mode_next          = MODE_PAYLOAD;
                end
              end
              MODE_PAYLOAD: begin
                res_valid          = 1'b1;
                res.kind           = KIND_PAYLOAD;
                res.payload        = data_byte;
                res.kind_of_frame  = current_type;
                payload_count_next = pc_inc;
                if (fin) begin
                  res.last          = 1'b1;
                  res.keep          = !drop;
                  first_frame_next  = 1'b0;
                  elapsed_next      = '0;
                  wd_armed_next     = 1'b1;
                  wd_count_next     = '0;
                  frame_length_next = '0;
                  current_type_next = TYPE_WAIT;
                  byte_count_next   = 4'd0;
                  mode_next         = MODE_LENGTH;
                end
              end
              default: begin
                mode_next = mode;
              end
            endcase
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_IDLE;
      byte_count    <= 4'd0;
      header        <= '0;
      frame_length  <= '0;
      payload_count <= '0;
      current_type  <= TYPE_WAIT;
      first_frame   <= 1'b1;
      elapsed       <= '0;
      wd_count      <= '0;
      wd_armed      <= 1'b0;
    end else begin
      mode          <= mode_next;
      byte_count    <= byte_count_next;
      header        <= header_next;
      frame_length  <= frame_length_next;
      payload_count <= payload_count_next;
      current_type  <= current_type_next;
      first_frame   <= first_frame_next;
      elapsed       <= elapsed_next;
      wd_count      <= wd_count_next;
      wd_armed      <= wd_armed_next;
    end
  end

  a_idle_disarmed: assert property (@(posedge clk) disable iff (rst)
    mode == MODE_IDLE |-> !wd_armed && wd_count == '0)
    else $error("watchdog armed outside a session");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    byte_count < 4'd12)
    else $error("byte count out of range");

  a_last_to_length: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.last |=> mode == MODE_LENGTH && !first_frame)
    else $error("frame end did not return to length parsing");

  a_end_to_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.kind == KIND_END |=> mode == MODE_IDLE)
    else $error("session end did not return to idle");

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.kind == KIND_START |=> mode == MODE_LENGTH && elapsed == '0)
    else $error("session start state wrong");

endmodule

// ----- rtl/core/video_stream_deframer_unit.sv -----
// ----------------------------------------------------------------------------
// video_stream_deframer_unit
// deframes a connect/byte/tick/disconnect stream into session and payload words
// ----------------------------------------------------------------------------
// One input word is taken every clock while the result side keeps up; each
// word gives at most one result word. A word passes an input register, one
// step of the session state machine and a result register, in that order,
// and a stall at the result side can hold it between them. While a result
// waits to be taken the input register holds at most one further word, and
// the input stalls once it is full. Register writes take effect at once and
// are meant to be made only while no word is in flight; there is no start-up
// clearing pass.
module video_stream_deframer_unit
  import vsd_pkg::*;
#(
  parameter int unsigned TIMER_WIDTH = TIMER_WIDTH_DEF
) (
  input logic       clk,
  input logic       rst,
  vsd_in_if.sink    stream,
  vsd_out_if.source result,
  vsd_cfg_if.sink   cfg
);

  logic        in_valid;
  logic [1:0]  in_op;
  logic [7:0]  in_byte;
  logic        advance;

  vsd_cfg_t    regs;
  logic        res_valid;
  vsd_result_t res;

  logic        out_valid;
  vsd_result_t out_data;

  assign advance      = in_valid && (!out_valid || result.ready);
  assign stream.ready = !in_valid || advance;
  assign cfg.ready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (stream.ready) begin
      in_valid <= stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stream.ready) begin
      in_op   <= stream.operation;
      in_byte <= stream.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.drop_threshold_ticks <= DROP_THRESHOLD_RST;
      regs.watchdog_ticks       <= WATCHDOG_RST;
      regs.max_frame_bytes      <= MAX_FRAME_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_DROP_THRESHOLD: regs.drop_threshold_ticks <= cfg.data[CFG_TIMER_W-1:0];
        REG_WATCHDOG:       regs.watchdog_ticks       <= cfg.data[CFG_TIMER_W-1:0];
        REG_MAX_FRAME:      regs.max_frame_bytes      <= cfg.data;
        default:            regs                      <= regs;
      endcase
    end
  end

  vsd_engine #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .operation (in_op),
    .data_byte (in_byte),
    .cfg       (regs),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || result.ready) begin
      out_valid <= advance && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || result.ready) begin
      out_data <= res;
    end
  end

  assign result.valid             = out_valid;
  assign result.kind              = out_data.kind;
  assign result.width             = out_data.width;
  assign result.height            = out_data.height;
  assign result.frames_per_second = out_data.frames_per_second;
  assign result.payload           = out_data.payload;
  assign result.last              = out_data.last;
  assign result.keep              = out_data.keep;
  assign result.kind_of_frame     = out_data.kind_of_frame;
  assign result.end_cause         = out_data.end_cause;

endmodule
